// ===== rtl/bbs_pkg.sv =====
package bbs_pkg;

    // Field and register widths
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 7;
    localparam int VALUE_W    = 17;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIZE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_BASE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SEED_ROOT  = CFG_IDX_W'(3);

    // Operation codes
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_RESEED   = 1'b1;

    // Reset values: modulus is 47 * 67, state is 207 squared mod modulus
    localparam logic [CFG_DATA_W-1:0] RST_MODULUS    = CFG_DATA_W'(47 * 67);
    localparam logic [CFG_DATA_W-1:0] RST_RANGE_SIZE = CFG_DATA_W'(1001);
    localparam logic [CFG_DATA_W-1:0] RST_RANGE_BASE = CFG_DATA_W'(0);
    localparam logic [CFG_DATA_W-1:0] RST_SEED_ROOT  = CFG_DATA_W'(207);
    localparam logic [31:0]           RST_STATE      = 32'((207 * 207) % (47 * 67));

    // Commands from controller to datapath
    typedef struct packed {
        logic mul;             // square operand, start reduction by modulus
        logic mul_seed;        // operand is seed root, else generator state
        logic step;            // one restoring-division iteration
        logic state_from_rem;  // state takes the remainder
        logic state_from_prod; // state takes the truncated square
        logic rng_start;       // start reduction of state by range size
        logic out_load;        // load the output register
        logic out_last;        // last flag for the loaded word
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic div_done;
        logic mod_zero;
        logic rng_zero;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/bbs_if.sv =====
interface bbs_in_if;
    import bbs_pkg::*;
    logic               valid;
    logic               ready;
    logic               op;
    logic [COUNT_W-1:0] count;
    modport source (output valid, output op, output count, input ready);
    modport sink   (input valid, input op, input count, output ready);
endinterface

interface bbs_out_if;
    import bbs_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;
    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface bbs_cfg_if;
    import bbs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bbs_datapath.sv =====
module bbs_datapath #(
    parameter int STATE_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bbs_cfg_if.sink          i_cfg,
    bbs_out_if.source        o_out,
    input  bbs_pkg::t_cmd    i_cmd,
    output bbs_pkg::t_status o_status
);
    import bbs_pkg::*;

    localparam int L_OPW = (STATE_WIDTH > CFG_DATA_W) ? STATE_WIDTH : CFG_DATA_W;
    localparam int L_PW  = 2 * L_OPW;
    localparam int L_CW  = $clog2(L_PW + 1);
    localparam logic [STATE_WIDTH-1:0] L_RST_STATE = STATE_WIDTH'(RST_STATE);

    logic [CFG_DATA_W-1:0]  r_modulus;
    logic [CFG_DATA_W-1:0]  r_range_size;
    logic [CFG_DATA_W-1:0]  r_range_base;
    logic [CFG_DATA_W-1:0]  r_seed_root;
    logic [STATE_WIDTH-1:0] r_state;
    logic [L_PW-1:0]        r_dvd;
    logic [CFG_DATA_W-1:0]  r_rem;
    logic [CFG_DATA_W-1:0]  r_div;
    logic [L_CW-1:0]        r_cnt;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_out_value;
    logic                   r_out_last;

    logic [L_OPW-1:0]      w_opnd;
    logic [L_PW-1:0]       w_prod;
    logic [CFG_DATA_W:0]   w_shift;
    logic                  w_ge;
    logic [CFG_DATA_W-1:0] w_rem_next;
    logic [VALUE_W-1:0]    w_reduced;

    // Square of seed root or state
    assign w_opnd = i_cmd.mul_seed ? L_OPW'(r_seed_root) : L_OPW'(r_state);
    assign w_prod = w_opnd * w_opnd;

    // One restoring-division step: shift in the next dividend bit
    assign w_shift    = {r_rem, r_dvd[L_PW-1]};
    assign w_ge       = w_shift >= {1'b0, r_div};
    assign w_rem_next = CFG_DATA_W'(w_ge ? (w_shift - {1'b0, r_div}) : w_shift);

    // Reduced value before adding the base
    assign w_reduced = (r_range_size == '0) ? VALUE_W'(r_state) : VALUE_W'(r_rem);

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= RST_MODULUS;
            r_range_size <= RST_RANGE_SIZE;
            r_range_base <= RST_RANGE_BASE;
            r_seed_root  <= RST_SEED_ROOT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_MODULUS:    r_modulus    <= i_cfg.data;
                REG_RANGE_SIZE: r_range_size <= i_cfg.data;
                REG_RANGE_BASE: r_range_base <= i_cfg.data;
                REG_SEED_ROOT:  r_seed_root  <= i_cfg.data;
                default: ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    // Generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_RST_STATE;
        end else if (i_cmd.state_from_rem) begin
            r_state <= STATE_WIDTH'(r_rem);
        end else if (i_cmd.state_from_prod) begin
            r_state <= STATE_WIDTH'(r_dvd);
        end
    end

    // Shared divider: dividend shifter, remainder, divisor and step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_dvd <= w_prod;
            r_rem <= '0;
            r_div <= r_modulus;
            r_cnt <= L_CW'(L_PW);
        end else if (i_cmd.rng_start) begin
            r_dvd <= {r_state, {(L_PW - STATE_WIDTH){1'b0}}};
            r_rem <= '0;
            r_div <= r_range_size;
            r_cnt <= L_CW'(STATE_WIDTH);
        end else if (i_cmd.step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_rem_next;
            r_cnt <= r_cnt - L_CW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= w_reduced + VALUE_W'(r_range_base);
            r_out_last  <= i_cmd.out_last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;
    assign o_out.last  = r_out_last;

    // Status to controller
    assign o_status.div_done = (r_cnt == '0);
    assign o_status.mod_zero = (r_modulus == '0);
    assign o_status.rng_zero = (r_range_size == '0);
    assign o_status.out_free = !r_out_valid || o_out.ready;

endmodule

// ===== rtl/bbs_ctrl.sv =====
module bbs_ctrl #(
    parameter int MAX_BURST = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bbs_in_if.sink           i_in,
    input  bbs_pkg::t_status i_status,
    output bbs_pkg::t_cmd    o_cmd
);
    import bbs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TRUNC,
        S_MOD,
        S_RSTART,
        S_RNG,
        S_OUT
    } t_fsm;

    localparam logic [COUNT_W-1:0] L_MAX = COUNT_W'(MAX_BURST);

    t_fsm               r_fsm,    n_fsm;
    logic               r_reseed, n_reseed;
    logic [COUNT_W-1:0] r_left,   n_left;
    logic [COUNT_W-1:0] w_count_sat;

    assign i_in.ready  = (r_fsm == S_IDLE);
    assign w_count_sat = (i_in.count > L_MAX) ? L_MAX : i_in.count;

    // Next state and commands
    always_comb begin
        n_fsm    = r_fsm;
        n_reseed = r_reseed;
        n_left   = r_left;
        o_cmd    = '0;
        case (r_fsm)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.op == OP_RESEED) begin
                        n_reseed = 1'b1;
                        n_fsm    = S_MUL;
                    end else if (w_count_sat != '0) begin
                        n_reseed = 1'b0;
                        n_left   = w_count_sat;
                        n_fsm    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul      = 1'b1;
                o_cmd.mul_seed = r_reseed;
                n_fsm          = i_status.mod_zero ? S_TRUNC : S_MOD;
            end
            S_TRUNC: begin
                o_cmd.state_from_prod = 1'b1;
                n_fsm                 = r_reseed ? S_IDLE : S_RSTART;
            end
            S_MOD: begin
                if (i_status.div_done) begin
                    o_cmd.state_from_rem = 1'b1;
                    n_fsm                = r_reseed ? S_IDLE : S_RSTART;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_RSTART: begin
                if (i_status.rng_zero) begin
                    n_fsm = S_OUT;
                end else begin
                    o_cmd.rng_start = 1'b1;
                    n_fsm           = S_RNG;
                end
            end
            S_RNG: begin
                if (i_status.div_done) begin
                    n_fsm = S_OUT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_OUT: begin
                // Hold until the output register can take the word
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_left == COUNT_W'(1));
                    n_left         = r_left - COUNT_W'(1);
                    n_fsm          = (r_left == COUNT_W'(1)) ? S_IDLE : S_MUL;
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_reseed <= 1'b0;
            r_left   <= '0;
        end else begin
            r_fsm    <= n_fsm;
            r_reseed <= n_reseed;
            r_left   <= n_left;
        end
    end

endmodule

// ===== rtl/blum_blum_shub_generator.sv =====
// Blum Blum Shub generator. A generate word asks for count values (1 to
// MAX_BURST, larger counts saturate, zero yields nothing); each value squares
// the state modulo the modulus register and is emitted as (state mod
// range_size) + range_base, with last set on the final value of the burst. A
// reseed word loads the state with seed_root squared mod modulus and emits
// nothing. A zero modulus truncates the square to STATE_WIDTH bits; a zero
// range_size skips the range reduction. Both reductions run on one shared
// restoring divider at one bit per cycle. One word is worked on at a time;
// input ready is high only between words. The output register lets the
// next value be computed while one waits. Configuration writes are always
// taken and belong only to idle periods.
module blum_blum_shub_generator #(
    parameter int STATE_WIDTH = 16,
    parameter int MAX_BURST   = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbs_in_if.sink    i_in,
    bbs_out_if.source o_out,
    bbs_cfg_if.sink   i_cfg
);
    import bbs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    bbs_ctrl #(
        .MAX_BURST (MAX_BURST)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Registers, multiplier, divider and output stage
    bbs_datapath #(
        .STATE_WIDTH (STATE_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule
